/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge, off while reset is high.
`define CRF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define CRF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/crf_pkg.sv */
package crf_pkg;

  typedef enum logic [1:0] {
    MODE_AUTOSAMPLE = 2'd0,
    MODE_NOT_EQUAL  = 2'd1,
    MODE_DEADBAND   = 2'd2,
    MODE_THRESHOLD  = 2'd3
  } mode_t;

  localparam logic [1:0] EDGE_RISING  = 2'd0;
  localparam logic [1:0] EDGE_FALLING = 2'd1;
  localparam logic [1:0] EDGE_BOTH    = 2'd2;

  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned PADDR_W   = 5;

  localparam logic [REG_IDX_W-1:0] REG_ENABLE    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MODE      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DEADBAND  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_EDGE      = 3'd5;

  localparam logic [15:0] PERIOD_RESET  = 16'd10;
  localparam logic [31:0] LAST_RESET    = 32'hffff_ffff;

  typedef struct packed {
    logic               report_enable;
    mode_t              report_mode;
    logic [15:0]        period_ms;
    logic [30:0]        deadband_size;
    logic signed [31:0] threshold_level;
    logic [1:0]         edge_select;
  } cfg_t;

  typedef struct packed {
    logic        report;
    logic [31:0] base_next;
  } dec_t;

endpackage

/* sv/crf_regs.sv */
module crf_regs
  import crf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.report_enable   <= 1'b0;
      cfg.report_mode     <= MODE_NOT_EQUAL;
      cfg.period_ms       <= PERIOD_RESET;
      cfg.deadband_size   <= '0;
      cfg.threshold_level <= '0;
      cfg.edge_select     <= EDGE_RISING;
    end else if (wr_en) begin
      unique case (idx)
        REG_ENABLE:    cfg.report_enable   <= pwdata[0];
        REG_MODE:      cfg.report_mode     <= mode_t'(pwdata[1:0]);
        REG_PERIOD:    cfg.period_ms       <= pwdata[15:0];
        REG_DEADBAND:  cfg.deadband_size   <= pwdata[30:0];
        REG_THRESHOLD: cfg.threshold_level <= signed'(pwdata);
        REG_EDGE:      cfg.edge_select     <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ENABLE:    prdata = {31'd0, cfg.report_enable};
      REG_MODE:      prdata = {30'd0, cfg.report_mode};
      REG_PERIOD:    prdata = {16'd0, cfg.period_ms};
      REG_DEADBAND:  prdata = {1'b0, cfg.deadband_size};
      REG_THRESHOLD: prdata = unsigned'(cfg.threshold_level);
      REG_EDGE:      prdata = {30'd0, cfg.edge_select};
      default:       prdata = '0;
    endcase
  end

endmodule

/* sv/crf_decide.sv */
module crf_decide
  import crf_pkg::*;
(
  input  cfg_t               cfg,
  input  logic signed [31:0] last_reported,
  input  logic [31:0]        period_base,
  input  logic               base_valid,
  input  logic signed [31:0] sample,
  input  logic [31:0]        now,
  output dec_t               dec
);

  logic [31:0]        eff_base;
  logic [31:0]        elapsed_ms;
  logic               elapsed;
  logic signed [33:0] s_x;
  logic signed [33:0] last_x;
  logic signed [33:0] db_x;
  logic signed [33:0] band_lo;
  logic signed [33:0] band_hi;
  logic               rise;
  logic               fall;
  logic               rise_en;
  logic               fall_en;
  logic               hit;

  assign eff_base   = base_valid ? period_base : now;
  assign elapsed_ms = now - eff_base;
  assign elapsed    = elapsed_ms >= {16'd0, cfg.period_ms};

  assign s_x     = 34'(sample);
  assign last_x  = 34'(last_reported);
  assign db_x    = signed'({3'd0, cfg.deadband_size});
  assign band_lo = last_x - db_x;
  assign band_hi = last_x + db_x;

  assign rise    = (last_reported <= cfg.threshold_level) && (sample > cfg.threshold_level);
  assign fall    = (last_reported > cfg.threshold_level) && (sample <= cfg.threshold_level);
  assign rise_en = (cfg.edge_select == EDGE_RISING) || (cfg.edge_select == EDGE_BOTH);
  assign fall_en = (cfg.edge_select == EDGE_FALLING) || (cfg.edge_select == EDGE_BOTH);

  always_comb begin
    case (cfg.report_mode)
      MODE_AUTOSAMPLE: hit = 1'b1;
      MODE_NOT_EQUAL:  hit = sample != last_reported;
      MODE_DEADBAND:   hit = (s_x < band_lo) || (s_x > band_hi);
      MODE_THRESHOLD:  hit = (rise_en && rise) || (fall_en && fall);
      default:         hit = 1'b0;
    endcase
  end

  assign dec.report    = cfg.report_enable && elapsed && hit;
  assign dec.base_next = elapsed ? now : eff_base;

endmodule

/* sv/change_report_filter_top.sv */
// Channel   Handshake             Payload
// -------   ---------             -------
// input     in_valid / in_ready   sample_value, now_ms
// output    out_valid / out_ready report, report_value
// config    APB psel/penable      paddr, pwdata, prdata (pready tied high)
//
// One transaction per cycle sustained while out_ready stays high; the path is the
// input register, then the result register, with the period and mode decision between them.
// While reporting is enabled, filter state updates at the edge that loads the result register.
// Synchronous active-high reset; filter state returns to last = -1, no base.
// A stalled output holds the result stage; the input register still takes a
// transaction when empty, then in_ready drops until the output drains.
module change_report_filter_top
  import crf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] sample_value,
  input  logic [31:0]        now_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               report,
  output logic signed [31:0] report_value
);

  cfg_t               cfg;
  dec_t               dec;
  logic               in_q_valid;
  logic signed [31:0] in_sample;
  logic [31:0]        in_now;
  logic signed [31:0] last_reported;
  logic [31:0]        period_base;
  logic               base_valid;
  logic               advance;
  logic               fire;

  crf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  crf_decide u_decide (
    .cfg           (cfg),
    .last_reported (last_reported),
    .period_base   (period_base),
    .base_valid    (base_valid),
    .sample        (in_sample),
    .now           (in_now),
    .dec           (dec)
  );

  assign advance  = !out_valid || out_ready;
  assign in_ready = !in_q_valid || advance;
  assign fire     = advance && in_q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_sample <= sample_value;
      in_now    <= now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      report       <= dec.report;
      report_value <= dec.report ? in_sample : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_reported <= signed'(LAST_RESET);
      period_base   <= '0;
      base_valid    <= 1'b0;
    end else if (fire && cfg.report_enable) begin
      period_base <= dec.base_next;
      base_valid  <= 1'b1;
      if (dec.report) begin
        last_reported <= in_sample;
      end
    end
  end

`include "assert_macros.svh"

  `CRF_ASSERT(a_last_only_on_report, !(fire && dec.report) |=> $stable(last_reported), "last value changed without a report")
  `CRF_ASSERT(a_report_needs_enable, (out_valid && report) |-> cfg.report_enable, "report while reporting disabled")
  `CRF_ASSERT(a_base_valid_sticks, base_valid |=> base_valid, "base_valid dropped outside reset")
  `CRF_ASSERT(a_no_value_without_report, (out_valid && !report) |-> (report_value == '0), "value without report")
  `CRF_ASSERT_ALWAYS(a_empty_accepts, !in_q_valid |-> in_ready, "empty input stage not ready")

endmodule

/* sim/tb_change_report_filter_top.sv */
typedef struct packed {
  logic               rpt;
  logic signed [31:0] val;
} report_exp_t;

class report_scoreboard;
  bit                 en;
  crf_pkg::mode_t     mode;
  bit [15:0]          period;
  bit [30:0]          band;
  int                 thr;
  bit [1:0]           edge_sel;

  int                 last_val;
  bit [31:0]          base;
  bit                 base_ok;

  report_exp_t        pending_q[$];
  int                 errors;

  function new();
    en       = 1'b0;
    mode     = crf_pkg::MODE_NOT_EQUAL;
    period   = crf_pkg::PERIOD_RESET;
    band     = '0;
    thr      = 0;
    edge_sel = crf_pkg::EDGE_RISING;
    last_val = -1;
    base     = '0;
    base_ok  = 1'b0;
    errors   = 0;
  endfunction

  function void set_reg(logic [crf_pkg::REG_IDX_W-1:0] idx, bit [31:0] v);
    case (idx)
      crf_pkg::REG_ENABLE:    en = v[0];
      crf_pkg::REG_MODE:      mode = crf_pkg::mode_t'(v[1:0]);
      crf_pkg::REG_PERIOD:    period = v[15:0];
      crf_pkg::REG_DEADBAND:  band = v[30:0];
      crf_pkg::REG_THRESHOLD: thr = v;
      crf_pkg::REG_EDGE:      edge_sel = v[1:0];
      default: ;
    endcase
  endfunction

  task log_mismatch(string msg);
    $display("ERROR: %s", msg);
    errors++;
  endtask

  function bit decide(int s);
    longint l;
    longint v;
    longint lv;
    longint d;
    bit rise_on;
    bit fall_on;
    l = last_val;
    v = s;
    lv = thr;
    d = band;
    rise_on = (edge_sel == crf_pkg::EDGE_RISING) || (edge_sel == crf_pkg::EDGE_BOTH);
    fall_on = (edge_sel == crf_pkg::EDGE_FALLING) || (edge_sel == crf_pkg::EDGE_BOTH);
    case (mode)
      crf_pkg::MODE_AUTOSAMPLE: return 1'b1;
      crf_pkg::MODE_NOT_EQUAL:  return v != l;
      crf_pkg::MODE_DEADBAND:   return (v < l - d) || (v > l + d);
      default: return (rise_on && l <= lv && v > lv) || (fall_on && l > lv && v <= lv);
    endcase
  endfunction

  function void note_sample(int s, bit [31:0] now);
    report_exp_t e;
    bit [31:0]   diff;
    e.rpt = 1'b0;
    e.val = '0;
    if (en) begin
      if (!base_ok) begin
        base = now;
        base_ok = 1'b1;
      end
      diff = now - base;
      if (diff >= {16'd0, period}) begin
        base = now;
        if (decide(s)) begin
          last_val = s;
          e.rpt = 1'b1;
          e.val = s;
        end
      end
    end
    pending_q.push_back(e);
  endfunction

  task check_report(logic r, logic signed [31:0] v);
    report_exp_t e;
    if (pending_q.size() == 0) begin
      log_mismatch($sformatf("result with nothing pending: report=%b value=%0d", r, v));
      return;
    end
    e = pending_q.pop_front();
    if (r !== e.rpt)
      log_mismatch($sformatf("report got %b want %b", r, e.rpt));
    if (v !== e.val)
      log_mismatch($sformatf("report_value got %0d want %0d", v, e.val));
  endtask
endclass

module tb_change_report_filter_top;
  timeunit 1ns;
  timeprecision 1ps;
  import crf_pkg::*;

  localparam int LIMIT = 500000;
  localparam int SAMPLE_MIN = int'(32'h8000_0000);
  localparam int SAMPLE_MAX = int'(32'h7fff_ffff);
  localparam logic [1:0] EDGE_NONE = 2'd3;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] sample_value = '0;
  logic [31:0]        now_ms = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               report;
  logic signed [31:0] report_value;

  report_scoreboard   sb;
  bit                 in_burst = 1'b0;
  bit                 out_burst = 1'b0;
  bit [31:0]          now_cur = '0;
  int                 cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  change_report_filter_top dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_value (sample_value),
    .now_ms       (now_ms),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .report       (report),
    .report_value (report_value)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_sample(sample_value, now_ms);
      if (out_valid && out_ready) sb.check_report(report, report_value);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, bit [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic send_sample(int s, bit [31:0] now);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    sample_value <= s;
    now_ms       <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic bit [31:0] pad_junk(bit [31:0] v, int w);
    bit [31:0] hi;
    hi = $urandom;
    if (w >= 32 || $urandom_range(0, 1) == 0) return v;
    return v | (hi & ~((32'h1 << w) - 32'h1));
  endfunction

  function automatic int pick_sample();
    longint l;
    longint d;
    longint off;
    l = sb.last_val;
    d = sb.band;
    off = $urandom_range(0, 2);
    off = off - 1;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: return SAMPLE_MIN;
          1: return SAMPLE_MAX;
          2: return 0;
          default: return -1;
        endcase
      end
      2, 3: return sb.last_val;
      4, 5, 6: return int'(($urandom_range(0, 1) ? l + d : l - d) + off);
      default: return int'(longint'(sb.thr) + off);
    endcase
  endfunction

  function automatic bit [31:0] next_now();
    bit [31:0] p;
    bit [31:0] step;
    p = sb.period;
    case ($urandom_range(0, 15))
      0: step = 0;
      1: step = $urandom;
      2: step = (p > 0) ? p - 1 : 0;
      3: step = p;
      default: step = $urandom_range(0, 2 * p + 3);
    endcase
    now_cur = now_cur + step;
    return now_cur;
  endfunction

  task automatic random_config();
    bit [31:0] v;
    write_reg(REG_ENABLE, pad_junk({31'd0, $urandom_range(0, 6) != 0}, 1));
    write_reg(REG_MODE, pad_junk($urandom_range(0, 3), 2));
    case ($urandom_range(0, 5))
      0: v = 0;
      1: v = 32'hffff;
      2: v = 1;
      default: v = $urandom_range(2, 20);
    endcase
    write_reg(REG_PERIOD, pad_junk(v, 16));
    case ($urandom_range(0, 3))
      0: v = 0;
      1: v = 32'h7fff_ffff;
      2: v = $urandom & 32'h7fff_ffff;
      default: v = $urandom_range(0, 50);
    endcase
    write_reg(REG_DEADBAND, pad_junk(v, 31));
    case ($urandom_range(0, 4))
      0: v = SAMPLE_MIN;
      1: v = SAMPLE_MAX;
      2: v = $urandom;
      default: v = sb.last_val + $urandom_range(0, 100) - 50;
    endcase
    write_reg(REG_THRESHOLD, v);
    write_reg(REG_EDGE, pad_junk($urandom_range(0, 3), 2));
    in_burst = ($urandom_range(0, 3) == 0);
  endtask

  initial begin
    int stall;
    int n_res;
    n_res = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      n_res++;
      if (n_res % 40 == 0) out_burst = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // disabled: no reports, no state change
    send_sample(7, 32'd0);
    send_sample(-3, 32'd50);
    drain();

    // reset config, not-equal; first enabled item sets the base
    write_reg(REG_ENABLE, 32'd1);
    send_sample(-1, 32'd100);
    send_sample(-1, 32'd105);
    send_sample(-1, 32'd110);
    send_sample(5, 32'd120);
    drain();

    write_reg(REG_MODE, MODE_AUTOSAMPLE);
    write_reg(REG_PERIOD, 32'd0);
    send_sample(SAMPLE_MIN, 32'd120);
    send_sample(SAMPLE_MAX, 32'd120);
    send_sample(0, 32'hffff_fffc);
    drain();

    // max period across the counter wrap
    write_reg(REG_MODE, MODE_NOT_EQUAL);
    write_reg(REG_PERIOD, 32'hffff);
    send_sample(1, 32'h0000_fffb);
    send_sample(2, 32'h0001_fffa);
    send_sample(3, 32'h0002_fff8);
    drain();

    // band edges are inside
    write_reg(REG_MODE, MODE_DEADBAND);
    write_reg(REG_PERIOD, 32'd0);
    write_reg(REG_DEADBAND, 32'd10);
    send_sample(12, 32'h0003_0000);
    send_sample(13, 32'h0003_0001);
    send_sample(3, 32'h0003_0002);
    send_sample(2, 32'h0003_0003);
    drain();

    write_reg(REG_DEADBAND, 32'h7fff_ffff);
    send_sample(SAMPLE_MIN, 32'h0003_0004);
    send_sample(SAMPLE_MAX, 32'h0003_0005);
    drain();

    write_reg(REG_MODE, MODE_THRESHOLD);
    write_reg(REG_EDGE, EDGE_BOTH);
    send_sample(0, 32'h0003_0006);
    send_sample(1, 32'h0003_0007);
    drain();

    write_reg(REG_EDGE, EDGE_NONE);
    send_sample(-1, 32'h0003_0008);
    drain();

    write_reg(REG_EDGE, EDGE_RISING);
    write_reg(REG_THRESHOLD, SAMPLE_MAX);
    send_sample(SAMPLE_MAX, 32'h0003_0009);
    drain();

    write_reg(REG_EDGE, EDGE_FALLING);
    write_reg(REG_THRESHOLD, SAMPLE_MIN);
    send_sample(SAMPLE_MIN, 32'h0003_000a);
    drain();

    write_reg(REG_SPARE_6, $urandom);
    write_reg(REG_SPARE_7, $urandom);
    send_sample(pick_sample(), 32'h0003_000b);
    drain();

    now_cur = 32'h0003_000b;
    for (int p = 0; p < 14; p++) begin
      random_config();
      for (int i = 0; i < 75; i++) send_sample(pick_sample(), next_now());
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.pending_q.size() != 0)
      sb.log_mismatch($sformatf("%0d results never arrived", sb.pending_q.size()));
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
